// ----- rtl/mct_pkg.sv -----
// ----------------------------------------------------------------------------
// mct_pkg: shared types and codes for the multi-channel compare timer
// Request operation codes, register selects, flag bit positions and the
// per-channel command and interrupt structs.
// ----------------------------------------------------------------------------
package mct_pkg;

   // request operations
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   // register selects
   localparam logic [3:0] REG_START   = 4'd0;
   localparam logic [3:0] REG_CONTROL = 4'd1;
   localparam logic [3:0] REG_ENABLE  = 4'd2;
   localparam logic [3:0] REG_STATUS  = 4'd3;
   localparam logic [3:0] REG_COUNT   = 4'd4;
   localparam logic [3:0] REG_GRA     = 4'd5;
   localparam logic [3:0] REG_GRB     = 4'd6;
   localparam logic [3:0] REG_BRA     = 4'd7;
   localparam logic [3:0] REG_BRB     = 4'd8;

   // flag / enable bit positions
   localparam int FLAG_A = 0;
   localparam int FLAG_B = 1;
   localparam int FLAG_V = 2;

   // width of the tick mask, the start register and each irq vector
   localparam int TICK_W = 5;

   localparam logic [15:0] ALL_ONES = 16'hFFFF;

   typedef struct packed {
      logic        tick;
      logic        rd;
      logic        wr;
      logic [3:0]  sel;
      logic [15:0] data;
   } lane_cmd_type;

   typedef struct packed {
      logic a;
      logic b;
      logic v;
   } lane_irq_type;

endpackage

// ----- rtl/multi_channel_compare_timer.sv -----
// Latency: a response is valid the cycle after its request is accepted.
// Throughput: one request per cycle while no response is stalled; all channel lanes
//   update in parallel in the accept cycle, the read mux is registered into the response.
// Reset (synchronous, active high) clears every timer register, the start
//   register, all flags and the response valid.
// ----------------------------------------------------------------------------
// multi_channel_compare_timer: multi-channel 16-bit compare-match timer
// Each request is a tick (advance running channels named in the mask), a
// register read or a register write. Every request gives one response with
// the read value and the per-channel interrupt requests after the request.
// ----------------------------------------------------------------------------
module multi_channel_compare_timer #(
   parameter int NUM_CHANNELS = 5
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [2:0]  req_channel,
   input  logic [3:0]  req_register_select,
   input  logic [15:0] req_write_data,
   input  logic [4:0]  req_tick_mask,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_read_data,
   output logic [4:0]  rsp_irq_match_a,
   output logic [4:0]  rsp_irq_match_b,
   output logic [4:0]  rsp_irq_overflow
);

   // start-register bits that map to real channels
   localparam logic [mct_pkg::TICK_W-1:0] RUN_MASK =
      mct_pkg::TICK_W'((64'd1 << NUM_CHANNELS) - 64'd1);

   logic                  req_fire;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_rd_ff,    rsp_rd_in;
   logic [mct_pkg::TICK_W-1:0] run_ff,  run_in;

   logic                  is_tick, is_read, is_write;
   logic [15:0]           lane_rd  [NUM_CHANNELS];
   mct_pkg::lane_irq_type lane_irq [NUM_CHANNELS];
   logic [15:0]           merge_rd;

   // Output register decouples the two sides: a new request is taken in
   // the same cycle the pending response is taken.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign is_tick  = req_fire && (req_operation == mct_pkg::OP_TICK);
   assign is_read  = req_fire && (req_operation == mct_pkg::OP_READ);
   assign is_write = req_fire && (req_operation == mct_pkg::OP_WRITE);

   // ---- channel lanes ----
   for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
      mct_pkg::lane_cmd_type cmd;
      logic                  hit;
      logic                  tick_bit;

      assign hit = (req_channel == 3'(g));
      if (g < mct_pkg::TICK_W) begin : g_tick
         assign tick_bit = req_tick_mask[g] & run_ff[g];
      end else begin : g_notick
         assign tick_bit = 1'b0;  // no tick bit reaches this channel
      end

      assign cmd.tick = is_tick && tick_bit;
      assign cmd.rd   = is_read && hit;
      assign cmd.wr   = is_write && hit;
      assign cmd.sel  = req_register_select;
      assign cmd.data = req_write_data;

      mct_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .read_value (lane_rd[g]),
         .irq        (lane_irq[g])
      );
   end

   // ---- merge: read mux and irq gathering ----
   mct_merge #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_merge (
      .is_read   (req_operation == mct_pkg::OP_READ),
      .channel   (req_channel),
      .sel       (req_register_select),
      .run_bits  (run_ff),
      .lane_rd   (lane_rd),
      .lane_irq  (lane_irq),
      .read_data (merge_rd),
      .irq_a     (rsp_irq_match_a),
      .irq_b     (rsp_irq_match_b),
      .irq_v     (rsp_irq_overflow)
   );

   // ---- start register (global, channel field ignored) ----
   always_comb begin
      run_in = run_ff;
      if (is_write && (req_register_select == mct_pkg::REG_START)) begin
         run_in = req_write_data[mct_pkg::TICK_W-1:0] & RUN_MASK;
      end
   end

   // ---- response register ----
   // Interrupt outputs come straight from lane state: that state only moves
   // on an accepted request, which also retires the pending response.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_rd_in    = rsp_rd_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_rd_in    = merge_rd;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         run_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         run_ff       <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rd_ff <= rsp_rd_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_rd_ff;

   // ---- assertions ----
   a_fire_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_stall_blocks_req : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while response stalled");

   a_run_in_range : assert property (@(posedge clock) disable iff (reset)
      (run_ff & ~RUN_MASK) == '0)
      else $error("start bit set for a missing channel");

   a_irq_stable : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_irq_match_a) &&
         $stable(rsp_irq_match_b) && $stable(rsp_irq_overflow))
      else $error("interrupt outputs moved under a stalled response");

endmodule

// ----- rtl/mct_lane.sv -----
// ----------------------------------------------------------------------------
// mct_lane: one timer channel
// Holds the channel's registers, advances the count on a tick, applies
// register writes and status read/clear handshaking, and offers the
// addressed register value to the merge stage.
// ----------------------------------------------------------------------------
module mct_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  mct_pkg::lane_cmd_type cmd,
   output logic [15:0]           read_value,
   output mct_pkg::lane_irq_type irq
);

   logic [6:0]  ctrl_ff,  ctrl_in;
   logic [2:0]  en_ff,    en_in;
   logic [2:0]  flags_ff, flags_in;
   logic [2:0]  seen_ff,  seen_in;
   logic [15:0] cnt_ff,   cnt_in;
   logic [15:0] gra_ff,   gra_in;
   logic [15:0] grb_ff,   grb_in;
   logic [15:0] bra_ff,   bra_in;
   logic [15:0] brb_ff,   brb_in;

   logic [1:0]  mode;
   logic        clear_hit;
   logic [15:0] cnt_tick;
   logic        wrap;
   logic [2:0]  tick_flags;
   logic [2:0]  clr;

   assign mode      = ctrl_ff[6:5];
   assign clear_hit = ((mode == 2'd1) && (cnt_ff == gra_ff)) ||
                      ((mode == 2'd2) && (cnt_ff == grb_ff));
   assign wrap      = !clear_hit && (cnt_ff == mct_pkg::ALL_ONES);
   assign cnt_tick  = clear_hit ? 16'd0 : cnt_ff + 16'd1;

   always_comb begin
      tick_flags                 = 3'b000;
      tick_flags[mct_pkg::FLAG_A] = (cnt_tick == gra_ff);
      tick_flags[mct_pkg::FLAG_B] = (cnt_tick == grb_ff);
      tick_flags[mct_pkg::FLAG_V] = wrap;
   end

   // flags clear only where they were read as set and now written 0
   assign clr = seen_ff & ~cmd.data[2:0];

   always_comb begin
      ctrl_in  = ctrl_ff;
      en_in    = en_ff;
      flags_in = flags_ff;
      seen_in  = seen_ff;
      cnt_in   = cnt_ff;
      gra_in   = gra_ff;
      grb_in   = grb_ff;
      bra_in   = bra_ff;
      brb_in   = brb_ff;
      if (cmd.tick) begin
         cnt_in   = cnt_tick;
         flags_in = flags_ff | tick_flags;
      end
      if (cmd.rd && (cmd.sel == mct_pkg::REG_STATUS)) begin
         seen_in = seen_ff | flags_ff;
      end
      if (cmd.wr) begin
         unique case (cmd.sel)
            mct_pkg::REG_CONTROL: ctrl_in = cmd.data[6:0];
            mct_pkg::REG_ENABLE:  en_in   = cmd.data[2:0];
            mct_pkg::REG_STATUS: begin
               flags_in = flags_ff & ~clr;
               seen_in  = seen_ff & ~clr;
            end
            mct_pkg::REG_COUNT:   cnt_in  = cmd.data;
            mct_pkg::REG_GRA:     gra_in  = cmd.data;
            mct_pkg::REG_GRB:     grb_in  = cmd.data;
            mct_pkg::REG_BRA:     bra_in  = cmd.data;
            mct_pkg::REG_BRB:     brb_in  = cmd.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff  <= '0;
         en_ff    <= '0;
         flags_ff <= '0;
         seen_ff  <= '0;
         cnt_ff   <= '0;
         gra_ff   <= '0;
         grb_ff   <= '0;
         bra_ff   <= '0;
         brb_ff   <= '0;
      end else begin
         ctrl_ff  <= ctrl_in;
         en_ff    <= en_in;
         flags_ff <= flags_in;
         seen_ff  <= seen_in;
         cnt_ff   <= cnt_in;
         gra_ff   <= gra_in;
         grb_ff   <= grb_in;
         bra_ff   <= bra_in;
         brb_ff   <= brb_in;
      end
   end

   // unused bits read as one
   always_comb begin
      unique case (cmd.sel)
         mct_pkg::REG_CONTROL: read_value = {9'h1FF, ctrl_ff};
         mct_pkg::REG_ENABLE:  read_value = {13'h1FFF, en_ff};
         mct_pkg::REG_STATUS:  read_value = {13'h1FFF, flags_ff};
         mct_pkg::REG_COUNT:   read_value = cnt_ff;
         mct_pkg::REG_GRA:     read_value = gra_ff;
         mct_pkg::REG_GRB:     read_value = grb_ff;
         mct_pkg::REG_BRA:     read_value = bra_ff;
         mct_pkg::REG_BRB:     read_value = brb_ff;
         default:              read_value = mct_pkg::ALL_ONES;
      endcase
   end

   assign irq.a = flags_ff[mct_pkg::FLAG_A] & en_ff[mct_pkg::FLAG_A];
   assign irq.b = flags_ff[mct_pkg::FLAG_B] & en_ff[mct_pkg::FLAG_B];
   assign irq.v = flags_ff[mct_pkg::FLAG_V] & en_ff[mct_pkg::FLAG_V];

endmodule

// ----- rtl/mct_merge.sv -----
// ----------------------------------------------------------------------------
// mct_merge: combines the channel lanes
// Picks the read value of the addressed channel (or the start register; zero
// for a non-read request) and gathers the per-channel interrupt requests into vectors.
// ----------------------------------------------------------------------------
module mct_merge #(
   parameter int NUM_CHANNELS = 5
) (
   input  logic                  is_read,
   input  logic [2:0]            channel,
   input  logic [3:0]            sel,
   input  logic [mct_pkg::TICK_W-1:0] run_bits,
   input  logic [15:0]           lane_rd  [NUM_CHANNELS],
   input  mct_pkg::lane_irq_type lane_irq [NUM_CHANNELS],
   output logic [15:0]           read_data,
   output logic [mct_pkg::TICK_W-1:0] irq_a,
   output logic [mct_pkg::TICK_W-1:0] irq_b,
   output logic [mct_pkg::TICK_W-1:0] irq_v
);

   logic [15:0] chan_rd;

   always_comb begin
      chan_rd = mct_pkg::ALL_ONES;  // missing channel reads all ones
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         if (channel == 3'(k)) chan_rd = lane_rd[k];
      end
   end

   always_comb begin
      priority if (!is_read) begin
         read_data = 16'd0;
      end else if (sel == mct_pkg::REG_START) begin
         read_data = {{(16 - mct_pkg::TICK_W){1'b1}}, run_bits};
      end else begin
         read_data = chan_rd;
      end
   end

   for (genvar g = 0; g < mct_pkg::TICK_W; g++) begin : g_irq
      if (g < NUM_CHANNELS) begin : g_on
         assign irq_a[g] = lane_irq[g].a;
         assign irq_b[g] = lane_irq[g].b;
         assign irq_v[g] = lane_irq[g].v;
      end else begin : g_off
         assign irq_a[g] = 1'b0;
         assign irq_b[g] = 1'b0;
         assign irq_v[g] = 1'b0;
      end
   end

endmodule
